FILE: design/eds_pkg.sv
// Shared types and constants of the elevator disk scheduler.
// Used by eds_front, eds_back and the top level; depends on nothing.
package eds_pkg;

    localparam int TRACK_BITS      = 10;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int PROC_W          = 8;
    localparam int TIME_W          = 16;
    localparam int DIST_W          = TRACK_BITS + 1;
    localparam int TA_W            = 27;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [TRACK_BITS-1:0] TRACK_MASK = {TRACK_BITS{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] CFG_TRACK_LIMIT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPERATION_TIME = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_TIME      = 2'd2;

    localparam logic [TRACK_BITS-1:0] RST_TRACK_LIMIT    = 10'd255;
    localparam logic [TIME_W-1:0]     RST_OPERATION_TIME = 16'd10;
    localparam logic [TIME_W-1:0]     RST_MOVE_TIME      = 16'd1;

    typedef enum logic {
        CMD_TICK    = 1'b0,
        CMD_REQUEST = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ_MUL,
        ST_REQ_OUT,
        ST_SCAN,
        ST_STATUS
    } state_t;

    // One classified request between front and back.
    typedef struct packed {
        cmd_t                  cmd;
        logic                  in_range;
        logic [TRACK_BITS-1:0] track;
        logic                  rd;
        logic [PROC_W-1:0]     proc;
    } cmd_item_t;

    // One stored pending request.
    typedef struct packed {
        logic [TRACK_BITS-1:0] track;
        logic                  rd;
        logic [PROC_W-1:0]     proc;
    } pend_entry_t;

    localparam int PEND_W = $bits(pend_entry_t);

    typedef struct packed {
        kind_t                 kind;
        logic [PROC_W-1:0]     proc;
        logic                  rd;
        logic [TA_W-1:0]       turnaround;
        logic                  accepted;
        logic [TRACK_BITS-1:0] arm;
        logic                  up;
        logic                  last;
    } out_item_t;

endpackage

FILE: design/eds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eds_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: design/eds_front.sv
// Front end: takes requests off the input stream, classifies them and
// queues them for the back end. Depends on eds_pkg.
module eds_front
    import eds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,
    input  logic [23:0]           s_tdata,
    input  logic [TRACK_BITS-1:0] eff_limit,
    output logic                  q_valid,
    output cmd_item_t             q_item,
    input  logic                  q_ready
);

    cmd_item_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;
    cmd_item_t               in_item;
    logic                    push, pop;

    always_comb begin
        in_item.cmd      = cmd_t'(s_tuser);
        in_item.track    = s_tdata[TRACK_BITS-1:0];
        in_item.rd       = s_tdata[TRACK_BITS];
        in_item.proc     = s_tdata[TRACK_BITS+PROC_W:TRACK_BITS+1];
        in_item.in_range = (s_tdata[TRACK_BITS-1:0] <= eff_limit);
    end

    assign s_tready = (cnt_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: design/eds_back.sv
// Back end: estimates turnaround for requests, keeps the pending table,
// scans it on each tick and drives the result register.
// Depends on eds_pkg and eds_ram.
module eds_back
    import eds_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  cmd_item_t             q_item,
    output logic                  q_ready,
    input  logic [TRACK_BITS-1:0] eff_limit,
    input  logic [TIME_W-1:0]     op_time,
    input  logic [TIME_W-1:0]     move_time,
    output logic                  out_valid,
    output out_item_t             out_item,
    input  logic                  out_ready
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t                state_reg, state_next;
    logic [TRACK_BITS-1:0] arm_reg, arm_next;
    logic                  up_reg, up_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         keep_reg, keep_next;
    logic [CW-1:0]         idx_inc;
    logic [TRACK_BITS-1:0] scan_track_reg, scan_track_next;
    logic [DIST_W-1:0]     dist_reg, dist_next;
    logic [TA_W-1:0]       prod_reg, prod_next;
    logic                  acc_reg, acc_next;
    logic                  rd_reg, rd_next;
    logic [PROC_W-1:0]     proc_reg, proc_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;
    logic                  out_free;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    pend_entry_t           ram_wdata, ram_rdata;

    logic [DIST_W-1:0]     sweep_len;
    logic                  req_ok;
    logic                  match;

    eds_ram #(
        .WIDTH (PEND_W),
        .DEPTH (QUEUE_DEPTH),
        .ADDR_W(AW)
    ) u_pend_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign q_ready   = (state_reg == ST_IDLE);
    assign idx_inc   = idx_reg + 1'b1;
    assign match     = (ram_rdata.track == scan_track_reg);

    // Sweep distance from the arm to the requested track.
    always_comb begin
        logic [DIST_W-1:0] cur, trk, lim;
        cur = {1'b0, arm_reg};
        trk = {1'b0, q_item.track};
        lim = {1'b0, eff_limit};
        if (up_reg) begin
            if (trk >= cur) begin
                sweep_len = trk - cur;
            end else if (cur > lim) begin
                sweep_len = cur - trk;
            end else begin
                sweep_len = (lim - cur) + (lim - trk);
            end
        end else begin
            if (trk <= cur) begin
                sweep_len = cur - trk;
            end else begin
                sweep_len = cur + trk;
            end
        end
    end

    assign req_ok = q_item.in_range && (count_reg < CW'(QUEUE_DEPTH));

    always_comb begin
        state_next      = state_reg;
        arm_next        = arm_reg;
        up_next         = up_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        scan_track_next = scan_track_reg;
        dist_next       = dist_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        rd_next         = rd_reg;
        proc_next       = proc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = '{track: q_item.track, rd: q_item.rd, proc: q_item.proc};
        ram_raddr       = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                ram_raddr = '0;
                if (q_valid) begin
                    if (q_item.cmd == CMD_REQUEST) begin
                        dist_next  = req_ok ? sweep_len : '0;
                        acc_next   = req_ok;
                        rd_next    = q_item.rd;
                        proc_next  = q_item.proc;
                        state_next = ST_REQ_MUL;
                        if (req_ok) begin
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        // Remember the serviced track, then step the arm.
                        scan_track_next = arm_reg;
                        idx_next        = '0;
                        keep_next       = '0;
                        if (up_reg) begin
                            if (arm_reg >= eff_limit) begin
                                up_next = 1'b0;
                            end else begin
                                arm_next = (arm_reg + 1'b1) & TRACK_MASK;
                            end
                        end else begin
                            if (arm_reg == '0) begin
                                up_next = 1'b1;
                            end else begin
                                arm_next = arm_reg - 1'b1;
                            end
                        end
                        state_next = (count_reg == '0) ? ST_STATUS : ST_SCAN;
                    end
                end
            end
            ST_REQ_MUL: begin
                prod_next  = {{(TA_W-DIST_W){1'b0}}, dist_reg}
                           * {{(TA_W-TIME_W){1'b0}}, move_time};
                state_next = ST_REQ_OUT;
            end
            ST_REQ_OUT: begin
                if (out_free) begin
                    out_valid_next      = 1'b1;
                    out_next.kind       = KIND_ACK;
                    out_next.proc       = proc_reg;
                    out_next.rd         = rd_reg;
                    out_next.turnaround = acc_reg
                                        ? prod_reg + {{(TA_W-TIME_W){1'b0}}, op_time}
                                        : '0;
                    out_next.accepted   = acc_reg;
                    out_next.arm        = arm_reg;
                    out_next.up         = up_reg;
                    out_next.last       = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    if (out_free) begin
                        out_valid_next      = 1'b1;
                        out_next.kind       = KIND_DONE;
                        out_next.proc       = ram_rdata.proc;
                        out_next.rd         = ram_rdata.rd;
                        out_next.turnaround = '0;
                        out_next.accepted   = 1'b0;
                        out_next.arm        = arm_reg;
                        out_next.up         = up_reg;
                        out_next.last       = 1'b0;
                    end
                end else begin
                    // Compact the survivor down to the keep slot.
                    ram_we    = 1'b1;
                    ram_waddr = keep_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    keep_next = keep_reg + 1'b1;
                end
                if (!match || out_free) begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc[AW-1:0];
                    if (idx_inc == count_reg) begin
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    out_valid_next      = 1'b1;
                    out_next.kind       = KIND_STATUS;
                    out_next.proc       = '0;
                    out_next.rd         = 1'b0;
                    out_next.turnaround = '0;
                    out_next.accepted   = 1'b0;
                    out_next.arm        = arm_reg;
                    out_next.up         = up_reg;
                    out_next.last       = 1'b1;
                    count_next          = keep_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            arm_reg       <= '0;
            up_reg        <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            arm_reg       <= arm_next;
            up_reg        <= up_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        keep_reg       <= keep_next;
        scan_track_reg <= scan_track_next;
        dist_reg       <= dist_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        rd_reg         <= rd_next;
        proc_reg       <= proc_next;
        out_reg        <= out_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("pending count above table depth");

    a_keep_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (keep_reg <= idx_reg && idx_reg < count_reg))
        else $error("scan indices out of order");

    a_status_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STATUS && out_free) |=>
            (state_reg == ST_IDLE && out_valid_reg && out_reg.last))
        else $error("tick did not end with a final status result");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> $stable(arm_reg))
        else $error("arm moved outside a tick start");

endmodule

FILE: design/elevator_disk_scheduler_unit.sv
// SCAN (elevator) disk arm scheduler, top level.
// Request stream in on s_*, results out on m_*, register writes on cfg_*.
// Depends on eds_pkg, eds_front, eds_back (and eds_ram below it).
//
// Each input request is either a tick (s_tuser = 0) or a new disk request
// (s_tuser = 1). A disk request gives one acknowledgement with the
// turnaround estimate and the accept flag. A tick gives one completion per
// pending entry on the current track, oldest first, and then a status
// result with the new arm position; m_tlast marks the final result.
// Input requests go through a 4-entry queue, so the input keeps flowing
// while the back end works or the output is stalled, until the queue fills.
// A disk request passes through ST_REQ_MUL and ST_REQ_OUT before its
// acknowledgement is registered. A tick scans the pending table RAM one
// entry per cycle while the output is not stalled, then gives its status;
// the back end takes no new input request until it is back in ST_IDLE.
// Reset clears the arm to track 0 sweeping up, empties the pending table
// and the queue, and loads the registers with their defaults (limit 255,
// operation time 10, move time 1). Table contents need no clearing.
// Write the registers only while the block is idle.
module elevator_disk_scheduler_unit
    import eds_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tuser,   // cmd
    input  logic [23:0]            s_tdata,   // req_track[9:0], req_read, process_id
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [1:0]             m_tuser,   // kind
    output logic [47:0]            m_tdata,   // out_process, out_read, turnaround,
                                              // accepted, arm_position, sweeping_up
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [TRACK_BITS-1:0] track_limit_reg;
    logic [TIME_W-1:0]     op_time_reg;
    logic [TIME_W-1:0]     move_time_reg;
    logic [TRACK_BITS-1:0] eff_limit;
    logic                  q_valid, q_ready;
    cmd_item_t             q_item;
    out_item_t             out_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_limit_reg <= RST_TRACK_LIMIT;
            op_time_reg     <= RST_OPERATION_TIME;
            move_time_reg   <= RST_MOVE_TIME;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TRACK_LIMIT:    track_limit_reg <= cfg_wdata[TRACK_BITS-1:0];
                CFG_OPERATION_TIME: op_time_reg     <= cfg_wdata;
                CFG_MOVE_TIME:      move_time_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Cap the limit at the largest track the arm can hold.
    assign eff_limit = (track_limit_reg > TRACK_MASK) ? TRACK_MASK : track_limit_reg;

    eds_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .eff_limit(eff_limit),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready)
    );

    eds_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_ready  (q_ready),
        .eff_limit(eff_limit),
        .op_time  (op_time_reg),
        .move_time(move_time_reg),
        .out_valid(m_tvalid),
        .out_item (out_item),
        .out_ready(m_tready)
    );

    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;
    assign m_tdata = {out_item.up, out_item.arm, out_item.accepted,
                      out_item.turnaround, out_item.rd, out_item.proc};

endmodule

FILE: test/tb_elevator_disk_scheduler_unit.sv
// Testbench for elevator_disk_scheduler_unit: drives requests and ticks, predicts
// every acknowledgement, completion and status result, and checks them in order.
// Depends on eds_pkg and the elevator_disk_scheduler_unit RTL.
module tb_elevator_disk_scheduler_unit
    import eds_pkg::*;
;

    localparam int CLK_PERIOD     = 12;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 400000;

    // Tracks the arm, the pending table and the registers, and keeps the
    // results each accepted request still owes.
    class disk_arm_tracker;
        out_item_t             due_results[$];
        pend_entry_t           pending_reqs[$];
        logic [TRACK_BITS-1:0] arm;
        logic                  up;
        logic [TRACK_BITS-1:0] limit;
        logic [TIME_W-1:0]     op_time;
        logic [TIME_W-1:0]     mv_time;
        int errors, items, requests, rejects, results, completions;

        function new();
            arm         = '0;
            up          = 1'b1;
            limit       = RST_TRACK_LIMIT;
            op_time     = RST_OPERATION_TIME;
            mv_time     = RST_MOVE_TIME;
            errors      = 0;
            items       = 0;
            requests    = 0;
            rejects     = 0;
            results     = 0;
            completions = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TRACK_LIMIT:    limit   = val[TRACK_BITS-1:0];
                CFG_OPERATION_TIME: op_time = val;
                CFG_MOVE_TIME:      mv_time = val;
                default: ;
            endcase
        endfunction

        // Tracks the arm must cover before reaching trk, following the sweep.
        function logic [DIST_W-1:0] sweep_dist(logic [TRACK_BITS-1:0] trk);
            if (up) begin
                if (trk >= arm)
                    return DIST_W'(trk) - arm;
                // arm left above a lowered limit: it turns around where it is
                if (arm > limit)
                    return DIST_W'(arm) - trk;
                return (DIST_W'(limit) - arm) + (DIST_W'(limit) - trk);
            end
            if (trk <= arm)
                return DIST_W'(arm) - trk;
            return DIST_W'(arm) + trk;
        endfunction

        function out_item_t make_result(kind_t k, logic [PROC_W-1:0] p, logic r,
                                        logic [TA_W-1:0] ta, logic acc, logic lst);
            out_item_t o;
            o.kind       = k;
            o.proc       = p;
            o.rd         = r;
            o.turnaround = ta;
            o.accepted   = acc;
            o.arm        = arm;
            o.up         = up;
            o.last       = lst;
            return o;
        endfunction

        function void apply_item(cmd_t cmd, logic [TRACK_BITS-1:0] trk, logic rd,
                                 logic [PROC_W-1:0] proc);
            pend_entry_t     kept[$];
            pend_entry_t     served[$];
            pend_entry_t     ent;
            longint unsigned ta;
            items++;
            if (cmd == CMD_REQUEST) begin
                requests++;
                // the 10-bit limit never exceeds the track mask, so no cap applies
                if (trk > limit || pending_reqs.size() >= DEF_QUEUE_DEPTH) begin
                    rejects++;
                    due_results.push_back(make_result(KIND_ACK, proc, rd, '0, 1'b0, 1'b1));
                    return;
                end
                ta = longint'(op_time) + longint'(sweep_dist(trk)) * longint'(mv_time);
                ent.track = trk;
                ent.rd    = rd;
                ent.proc  = proc;
                pending_reqs.push_back(ent);
                due_results.push_back(make_result(KIND_ACK, proc, rd, TA_W'(ta), 1'b1, 1'b1));
                return;
            end
            foreach (pending_reqs[i]) begin
                if (pending_reqs[i].track == arm)
                    served.push_back(pending_reqs[i]);
                else
                    kept.push_back(pending_reqs[i]);
            end
            pending_reqs = kept;
            // step the arm, or turn it around at either end
            if (up) begin
                if (arm >= limit)
                    up = 1'b0;
                else
                    arm = arm + 1'b1;
            end else begin
                if (arm == '0)
                    up = 1'b1;
                else
                    arm = arm - 1'b1;
            end
            foreach (served[i])
                due_results.push_back(make_result(KIND_DONE, served[i].proc, served[i].rd,
                                                  '0, 1'b0, 1'b0));
            due_results.push_back(make_result(KIND_STATUS, '0, 1'b0, '0, 1'b0, 1'b1));
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task cmp_field(string name, longint unsigned got, longint unsigned want, int seq);
            if (got != want)
                report_mismatch($sformatf("result %0d field %s: got %0d, want %0d",
                                          seq, name, got, want));
        endtask

        task check_result(logic [1:0] kind, logic [47:0] data, logic lst);
            out_item_t want;
            results++;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d: kind %0d data %h",
                                          results, kind, data));
                return;
            end
            want = due_results.pop_front();
            if (want.kind == KIND_DONE)
                completions++;
            cmp_field("kind", kind, want.kind, results);
            cmp_field("out_process", data[7:0], want.proc, results);
            cmp_field("out_read", data[8], want.rd, results);
            cmp_field("turnaround", data[35:9], want.turnaround, results);
            cmp_field("accepted", data[36], want.accepted, results);
            cmp_field("arm_position", data[46:37], want.arm, results);
            cmp_field("sweeping_up", data[47], want.up, results);
            cmp_field("last", lst, want.last, results);
        endtask
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic                   s_tuser   = 1'b0;
    logic [23:0]            s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [1:0]             m_tuser;
    logic [47:0]            m_tdata;
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;

    disk_arm_tracker sb = new();

    elevator_disk_scheduler_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Result side: random stalls, plus a long hold-off when one is asked for.
    always @(negedge aclk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // Offer one request; called and returns at a falling edge, valid left high.
    task send_item(cmd_t cmd, logic [TRACK_BITS-1:0] trk, logic rd, logic [PROC_W-1:0] proc);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, proc, rd, trk};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.apply_item(cmd, trk, rd, proc);
        @(negedge aclk);
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet.
    task drain();
        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task program_regs(logic [TRACK_BITS-1:0] lim, logic [TIME_W-1:0] op, logic [TIME_W-1:0] mv);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TRACK_LIMIT;
        cfg_wdata <= CFG_DATA_W'(lim);
        sb.set_reg(CFG_TRACK_LIMIT, CFG_DATA_W'(lim));
        @(negedge aclk);
        cfg_index <= CFG_OPERATION_TIME;
        cfg_wdata <= op;
        sb.set_reg(CFG_OPERATION_TIME, op);
        @(negedge aclk);
        cfg_index <= CFG_MOVE_TIME;
        cfg_wdata <= mv;
        sb.set_reg(CFG_MOVE_TIME, mv);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mix of ticks (with junk fields) and requests, mostly on reachable tracks.
    task run_random(int n, int span);
        logic [TRACK_BITS-1:0] trk;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 12)
                trk = TRACK_BITS'($urandom_range(1023));
            else
                trk = TRACK_BITS'($urandom_range(span));
            if ($urandom_range(99) < 50)
                send_item(CMD_TICK, TRACK_BITS'($urandom_range(1023)),
                          1'($urandom_range(1)), PROC_W'($urandom_range(255)));
            else
                send_item(CMD_REQUEST, trk, 1'($urandom_range(1)),
                          PROC_W'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct = 30;
        rx_idle_pct = 57;
        // default registers: request on the arm track, one out of range, serve it
        send_item(CMD_REQUEST, 10'd0, 1'b1, 8'd0);
        send_item(CMD_REQUEST, 10'd1023, 1'b0, 8'd255);
        send_item(CMD_TICK, '0, 1'b0, '0);
        drain();

        // limit of zero with the arm left above it
        program_regs(10'd0, 16'd0, 16'hFFFF);
        send_item(CMD_REQUEST, 10'd0, 1'b0, 8'd2);
        send_item(CMD_REQUEST, 10'd1, 1'b1, 8'd3);
        repeat (4) send_item(CMD_TICK, '0, 1'b0, '0);
        drain();

        // fill the table on one track, overflow it, then serve all at once
        program_regs(10'd1023, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < DEF_QUEUE_DEPTH; i++)
            send_item(CMD_REQUEST, 10'd0, i[0], PROC_W'(i * 17));
        send_item(CMD_REQUEST, 10'd5, 1'b1, 8'd77);
        send_item(CMD_TICK, '0, 1'b0, '0);
        drain();

        program_regs(10'd3, TIME_W'($urandom_range(65535)), TIME_W'($urandom_range(7)));
        run_random(170, 3);
        drain();

        tx_idle_pct = 57;
        rx_idle_pct = 30;
        program_regs(10'd31, TIME_W'($urandom_range(65535)), TIME_W'($urandom_range(65535)));
        run_random(170, 31);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(10'd1023, TIME_W'($urandom_range(65535)), TIME_W'($urandom_range(65535)));
        // stall the result side long enough to back up the input
        hold_asked++;
        run_random(170, 63);
        drain();

        $display("covered %0d items: %0d requests (%0d rejected), %0d ticks",
                 sb.items, sb.requests, sb.rejects, sb.items - sb.requests);
        $display("checked %0d results with %0d completions over limits 0 to 1023",
                 sb.results, sb.completions);
        if (sb.errors == 0)
            $display("tb_elevator_disk_scheduler_unit: clean");
        else
            $display("tb_elevator_disk_scheduler_unit: errors");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results still owed", sb.due_results.size());
        $display("tb_elevator_disk_scheduler_unit: errors");
        $finish;
    end

endmodule
